// ===== rtl/skf_pkg.sv =====
package skf_pkg;

   localparam int unsigned FIELD_BITS     = 32;
   localparam int unsigned VAR_BITS       = 31;
   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned PROG_LEN       = 24;
   localparam int unsigned PC_BITS        = 5;

   typedef logic signed [FIELD_BITS-1:0] word_type;
   typedef logic [VAR_BITS-1:0]          var_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_TRANSITION  = 3'd0,
      REG_OBSERVATION = 3'd1,
      REG_PROC_NOISE  = 3'd2,
      REG_MEAS_NOISE  = 3'd3,
      REG_INIT_EST    = 3'd4,
      REG_INIT_VAR    = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      OP_NOP       = 3'd0,
      OP_MUL_ISSUE = 3'd1,
      OP_MUL_ROUND = 3'd2,
      OP_ADD       = 3'd3,
      OP_SUB       = 3'd4,
      OP_DIV       = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      SRC_A    = 4'd0,
      SRC_H    = 4'd1,
      SRC_Q    = 4'd2,
      SRC_R    = 4'd3,
      SRC_X    = 4'd4,
      SRC_P    = 4'd5,
      SRC_Z    = 4'd6,
      SRC_T    = 4'd7,
      SRC_X1   = 4'd8,
      SRC_P1   = 4'd9,
      SRC_PH   = 4'd10,
      SRC_GAIN = 4'd11,
      SRC_ONE  = 4'd12
   } src_type;

   typedef enum logic [2:0] {
      DST_NONE = 3'd0,
      DST_T    = 3'd1,
      DST_X1   = 3'd2,
      DST_P1   = 3'd3,
      DST_PH   = 3'd4,
      DST_X    = 3'd5,
      DST_P    = 3'd6
   } dst_type;

   typedef struct packed {
      op_type  op;
      src_type src_a;
      src_type src_b;
      dst_type dst;
   } uop_type;

   typedef struct packed {
      logic    load_z;
      logic    csr_we;
      logic    load_out;
      uop_type uop;
   } cmd_type;

   localparam uop_type NOP_UOP = '{OP_NOP, SRC_T, SRC_T, DST_NONE};
   localparam logic [PC_BITS-1:0] LAST_PC = PC_BITS'(PROG_LEN - 1);

   // Predict, gain, then correct; each multiply is an issue step and a round step.
   function automatic uop_type prog_step(input logic [PC_BITS-1:0] pc);
      uop_type u;
      u = NOP_UOP;
      unique case (pc)
         5'd0:  u = '{OP_MUL_ISSUE, SRC_A,    SRC_X,  DST_NONE};
         5'd1:  u = '{OP_MUL_ROUND, SRC_T,    SRC_T,  DST_X1};
         5'd2:  u = '{OP_MUL_ISSUE, SRC_A,    SRC_A,  DST_NONE};
         5'd3:  u = '{OP_MUL_ROUND, SRC_T,    SRC_T,  DST_T};
         5'd4:  u = '{OP_MUL_ISSUE, SRC_T,    SRC_P,  DST_NONE};
         5'd5:  u = '{OP_MUL_ROUND, SRC_T,    SRC_T,  DST_T};
         5'd6:  u = '{OP_ADD,       SRC_T,    SRC_Q,  DST_P1};
         5'd7:  u = '{OP_MUL_ISSUE, SRC_P1,   SRC_H,  DST_NONE};
         5'd8:  u = '{OP_MUL_ROUND, SRC_T,    SRC_T,  DST_PH};
         5'd9:  u = '{OP_MUL_ISSUE, SRC_PH,   SRC_H,  DST_NONE};
         5'd10: u = '{OP_MUL_ROUND, SRC_T,    SRC_T,  DST_T};
         5'd11: u = '{OP_ADD,       SRC_T,    SRC_R,  DST_T};
         5'd12: u = '{OP_DIV,       SRC_PH,   SRC_T,  DST_NONE};
         5'd13: u = '{OP_MUL_ISSUE, SRC_H,    SRC_X1, DST_NONE};
         5'd14: u = '{OP_MUL_ROUND, SRC_T,    SRC_T,  DST_T};
         5'd15: u = '{OP_SUB,       SRC_Z,    SRC_T,  DST_T};
         5'd16: u = '{OP_MUL_ISSUE, SRC_GAIN, SRC_T,  DST_NONE};
         5'd17: u = '{OP_MUL_ROUND, SRC_T,    SRC_T,  DST_T};
         5'd18: u = '{OP_ADD,       SRC_X1,   SRC_T,  DST_X};
         5'd19: u = '{OP_MUL_ISSUE, SRC_GAIN, SRC_H,  DST_NONE};
         5'd20: u = '{OP_MUL_ROUND, SRC_T,    SRC_T,  DST_T};
         5'd21: u = '{OP_SUB,       SRC_ONE,  SRC_T,  DST_T};
         5'd22: u = '{OP_MUL_ISSUE, SRC_T,    SRC_P1, DST_NONE};
         5'd23: u = '{OP_MUL_ROUND, SRC_T,    SRC_T,  DST_P};
         default: u = NOP_UOP;
      endcase
      return u;
   endfunction

endpackage

// ===== rtl/skf_div.sv =====
module skf_div
   import skf_pkg::*;
#(
   parameter int unsigned WORD_BITS = 32,
   parameter int unsigned FRAC      = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type num,
   input  word_type den,
   output logic     done,
   output word_type quotient,
   output logic     sat
);

   localparam int unsigned CNT_BITS = $clog2(WORD_BITS);
   localparam longint HI = (longint'(1) <<< (WORD_BITS - 1)) - 1;
   localparam longint LO = -HI - 1;

   typedef enum logic [2:0] {
      D_IDLE = 3'b001,
      D_LOOP = 3'b010,
      D_FIX  = 3'b100
   } div_state_type;

   div_state_type          state_ff, state_in;
   logic [32:0]            rem_ff, rem_in;
   logic [32:0]            dm_ff, dm_in;
   logic [WORD_BITS-1:0]   lo_ff, lo_in;
   logic [WORD_BITS-1:0]   quo_ff, quo_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic                   zero_ff, zero_in;
   logic                   ovf_ff, ovf_in;

   longint      num_l, den_l, num_mag, den_mag, dividend, upper, q_mag, q_signed, q_final;
   logic [33:0] trial, diff;
   logic        fits;

   always_comb begin
      num_l    = longint'(num);
      den_l    = longint'(den);
      num_mag  = (num_l < 0) ? -num_l : num_l;
      den_mag  = (den_l < 0) ? -den_l : den_l;
      dividend = num_mag <<< FRAC;
      upper    = dividend >>> WORD_BITS;

      trial = {rem_ff, lo_ff[WORD_BITS-1]};
      diff  = trial - {1'b0, dm_ff};
      fits  = trial >= {1'b0, dm_ff};

      q_mag    = longint'(quo_ff);
      q_signed = neg_ff ? -q_mag : q_mag;

      state_in = state_ff;
      rem_in   = rem_ff;
      dm_in    = dm_ff;
      lo_in    = lo_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      ovf_in   = ovf_ff;

      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               dm_in   = den_mag[32:0];
               rem_in  = upper[32:0];
               lo_in   = dividend[WORD_BITS-1:0];
               quo_in  = '0;
               cnt_in  = CNT_BITS'(WORD_BITS - 1);
               neg_in  = num[FIELD_BITS-1] ^ den[FIELD_BITS-1];
               zero_in = (den_l == 0);
               ovf_in  = (upper >= den_mag);
               state_in = ((den_l == 0) || (upper >= den_mag)) ? D_FIX : D_LOOP;
            end
         end
         D_LOOP: begin
            rem_in = fits ? diff[32:0] : trial[32:0];
            quo_in = {quo_ff[WORD_BITS-2:0], fits};
            lo_in  = lo_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = D_FIX;
            end
         end
         D_FIX: begin
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase

      if (zero_ff) begin
         q_final = 0;
         sat     = 1'b1;
      end else if (ovf_ff) begin
         q_final = neg_ff ? LO : HI;
         sat     = 1'b1;
      end else if (q_signed > HI) begin
         q_final = HI;
         sat     = 1'b1;
      end else if (q_signed < LO) begin
         q_final = LO;
         sat     = 1'b1;
      end else begin
         q_final = q_signed;
         sat     = 1'b0;
      end
      quotient = $signed(q_final[FIELD_BITS-1:0]);
      done     = (state_ff == D_FIX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dm_ff   <= dm_in;
      lo_ff   <= lo_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      ovf_ff  <= ovf_in;
   end

endmodule

// ===== rtl/skf_dp.sv =====
module skf_dp
   import skf_pkg::*;
#(
   parameter int unsigned WORD_BITS = 32,
   parameter int unsigned FRAC      = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  word_type                  csr_data,
   input  word_type                  req_measurement,
   output logic                      div_done,
   output word_type                  rsp_estimate,
   output word_type                  rsp_kalman_gain,
   output logic                      rsp_overflow_flag
);

   localparam longint HI       = (longint'(1) <<< (WORD_BITS - 1)) - 1;
   localparam longint LO       = -HI - 1;
   localparam longint ONE_L    = longint'(1) <<< FRAC;
   localparam longint RND_HALF = longint'(1) <<< (FRAC - 1);
   localparam longint VMAX     = 64'h7FFF_FFFF;
   localparam longint A_L      = (ONE_L > VMAX) ? VMAX : ONE_L;
   localparam longint Q_L      = (200 * ONE_L > VMAX) ? VMAX : 200 * ONE_L;
   localparam longint R_L      = (500 * ONE_L > VMAX) ? VMAX : 500 * ONE_L;
   localparam longint P_L      = (A_L > HI) ? HI : A_L;

   localparam word_type ONE_WORD = 32'(ONE_L);
   localparam word_type A_RST    = 32'(A_L);
   localparam var_type  Q_RST    = 31'(Q_L);
   localparam var_type  R_RST    = 31'(R_L);
   localparam word_type P_RST    = 32'(P_L);

   word_type a_ff, a_in, h_ff, h_in;
   var_type  q_ff, q_in, r_ff, r_in;
   word_type x_ff, x_in, p_ff, p_in;
   word_type z_ff, z_in, t_ff, t_in, x1_ff, x1_in, p1_ff, p1_in;
   word_type ph_ff, ph_in, gain_ff, gain_in;
   logic signed [63:0] prod_ff, prod_in;
   logic     flag_ff, flag_in;
   word_type est_out_ff, est_out_in, gain_out_ff, gain_out_in;
   logic     flag_out_ff, flag_out_in;

   word_type opa, opb, alu_res, div_q;
   longint   alu_pre, rnd, csr_x, csr_p;
   logic     alu_we, alu_ovf, div_start, div_sat;

   function automatic logic over_range(input longint v);
      return (v > HI) || (v < LO);
   endfunction

   function automatic word_type sat_word(input longint v);
      longint c;
      c = v;
      if (v > HI) begin
         c = HI;
      end else if (v < LO) begin
         c = LO;
      end
      return $signed(c[FIELD_BITS-1:0]);
   endfunction

   function automatic word_type operand(input src_type s);
      word_type v;
      case (s)
         SRC_A:    v = a_ff;
         SRC_H:    v = h_ff;
         SRC_Q:    v = $signed({1'b0, q_ff});
         SRC_R:    v = $signed({1'b0, r_ff});
         SRC_X:    v = x_ff;
         SRC_P:    v = p_ff;
         SRC_Z:    v = z_ff;
         SRC_X1:   v = x1_ff;
         SRC_P1:   v = p1_ff;
         SRC_PH:   v = ph_ff;
         SRC_GAIN: v = gain_ff;
         SRC_ONE:  v = ONE_WORD;
         default:  v = t_ff;
      endcase
      return v;
   endfunction

   assign div_start = (cmd.uop.op == OP_DIV);

   skf_div #(
      .WORD_BITS (WORD_BITS),
      .FRAC      (FRAC)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (ph_ff),
      .den      (t_ff),
      .done     (div_done),
      .quotient (div_q),
      .sat      (div_sat)
   );

   always_comb begin
      opa = operand(cmd.uop.src_a);
      opb = operand(cmd.uop.src_b);
      rnd = prod_ff + RND_HALF;
      case (cmd.uop.op)
         OP_MUL_ROUND: alu_pre = rnd >>> FRAC;
         OP_SUB:       alu_pre = longint'(opa) - longint'(opb);
         default:      alu_pre = longint'(opa) + longint'(opb);
      endcase
      alu_res = sat_word(alu_pre);
      alu_ovf = over_range(alu_pre);
      alu_we  = (cmd.uop.op == OP_MUL_ROUND) || (cmd.uop.op == OP_ADD) ||
                (cmd.uop.op == OP_SUB);
      csr_x   = longint'(csr_data);
      csr_p   = longint'({1'b0, csr_data[VAR_BITS-1:0]});

      a_in        = a_ff;
      h_in        = h_ff;
      q_in        = q_ff;
      r_in        = r_ff;
      x_in        = x_ff;
      p_in        = p_ff;
      z_in        = z_ff;
      t_in        = t_ff;
      x1_in       = x1_ff;
      p1_in       = p1_ff;
      ph_in       = ph_ff;
      gain_in     = gain_ff;
      prod_in     = prod_ff;
      flag_in     = flag_ff;
      est_out_in  = est_out_ff;
      gain_out_in = gain_out_ff;
      flag_out_in = flag_out_ff;

      if (cmd.csr_we) begin
         unique case (csr_index)
            REG_TRANSITION:  a_in = csr_data;
            REG_OBSERVATION: h_in = csr_data;
            REG_PROC_NOISE:  q_in = csr_data[VAR_BITS-1:0];
            REG_MEAS_NOISE:  r_in = csr_data[VAR_BITS-1:0];
            REG_INIT_EST:    x_in = sat_word(csr_x);
            REG_INIT_VAR:    p_in = sat_word(csr_p);
            default: ;
         endcase
      end

      if (cmd.uop.op == OP_MUL_ISSUE) begin
         prod_in = longint'(opa) * longint'(opb);
      end

      if (alu_we) begin
         flag_in = flag_ff | alu_ovf;
         case (cmd.uop.dst)
            DST_T:  t_in  = alu_res;
            DST_X1: x1_in = alu_res;
            DST_P1: p1_in = alu_res;
            DST_PH: ph_in = alu_res;
            DST_X:  x_in  = alu_res;
            DST_P:  p_in  = alu_res;
            default: ;
         endcase
      end

      if (div_done) begin
         gain_in = div_q;
         flag_in = flag_ff | div_sat;
      end

      if (cmd.load_z) begin
         z_in    = req_measurement;
         flag_in = 1'b0;
      end

      if (cmd.load_out) begin
         est_out_in  = x_ff;
         gain_out_in = gain_ff;
         flag_out_in = flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= A_RST;
         h_ff <= A_RST;
         q_ff <= Q_RST;
         r_ff <= R_RST;
         x_ff <= '0;
         p_ff <= P_RST;
      end else begin
         a_ff <= a_in;
         h_ff <= h_in;
         q_ff <= q_in;
         r_ff <= r_in;
         x_ff <= x_in;
         p_ff <= p_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff        <= z_in;
      t_ff        <= t_in;
      x1_ff       <= x1_in;
      p1_ff       <= p1_in;
      ph_ff       <= ph_in;
      gain_ff     <= gain_in;
      prod_ff     <= prod_in;
      flag_ff     <= flag_in;
      est_out_ff  <= est_out_in;
      gain_out_ff <= gain_out_in;
      flag_out_ff <= flag_out_in;
   end

   assign rsp_estimate      = est_out_ff;
   assign rsp_kalman_gain   = gain_out_ff;
   assign rsp_overflow_flag = flag_out_ff;

endmodule

// ===== rtl/skf_ctrl.sv =====
module skf_ctrl
   import skf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    csr_valid,
   output logic    csr_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  logic    div_done,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RUN  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } ctrl_state_type;

   ctrl_state_type     state_ff, state_in;
   logic [PC_BITS-1:0] pc_ff, pc_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.load_z   = 1'b0;
      cmd.csr_we   = 1'b0;
      cmd.load_out = 1'b0;
      cmd.uop      = NOP_UOP;

      unique case (state_ff)
         ST_IDLE: begin
            cmd.csr_we = csr_valid;
            if (req_valid) begin
               cmd.load_z = 1'b1;
               pc_in      = '0;
               state_in   = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.uop = prog_step(pc_ff);
            if (cmd.uop.op == OP_DIV) begin
               state_in = ST_DIV;
            end else if (pc_ff == LAST_PC) begin
               state_in = ST_DONE;
            end else begin
               pc_in = pc_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               pc_in    = pc_ff + 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/scalar_kalman_filter_core.sv =====
// A new request is accepted only in idle, after the previous one has loaded its response.
// The multiplier is shared by every multiply of the program, and the divider, which produces
// one quotient bit per cycle, skips its loop when the denominator is zero or the quotient
// overflows W bits, W = min(DATA_WIDTH, 32).
// Reset is synchronous and active high; it restores the CSR registers and the filter state
// to their default values and drops rsp_valid.
module scalar_kalman_filter_core
   import skf_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = 32,
   parameter int unsigned FRAC_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  word_type                  req_measurement,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output word_type                  rsp_estimate,
   output word_type                  rsp_kalman_gain,
   output logic                      rsp_overflow_flag,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  word_type                  csr_data
);

   localparam int unsigned WORD_BITS = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
   localparam int unsigned FRAC      = (FRAC_BITS > 30) ? 30 :
                                       ((FRAC_BITS < 1) ? 1 : FRAC_BITS);

   cmd_type cmd;
   logic    div_done;

   skf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .div_done  (div_done),
      .cmd       (cmd)
   );

   skf_dp #(
      .WORD_BITS (WORD_BITS),
      .FRAC      (FRAC)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_measurement   (req_measurement),
      .div_done          (div_done),
      .rsp_estimate      (rsp_estimate),
      .rsp_kalman_gain   (rsp_kalman_gain),
      .rsp_overflow_flag (rsp_overflow_flag)
   );

endmodule

// ===== rtl/skf_chk.sv =====
module skf_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_estimate,
   input logic [31:0] rsp_kalman_gain,
   input logic        rsp_overflow_flag,
   input logic        csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_estimate) &&
      $stable(rsp_kalman_gain) && $stable(rsp_overflow_flag))
      else $error("response dropped or changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready ##1 !req_ready)
      else $error("new request taken while one is being processed");

   a_no_csr_when_busy: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> !csr_ready)
      else $error("register write accepted while a request is in flight");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind scalar_kalman_filter_core skf_chk u_skf_chk (.*);

// ===== bench/skf_checker.sv =====
module skf_checker
   import skf_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = 32,
   parameter int unsigned FRAC_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  word_type                  req_measurement,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  word_type                  rsp_estimate,
   input  word_type                  rsp_kalman_gain,
   input  logic                      rsp_overflow_flag,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  word_type                  csr_data,
   output int unsigned               pending_results,
   output int unsigned               mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAT_BITS = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 2) ? 2 : DATA_WIDTH);
   localparam int Q_BITS   = (FRAC_BITS > 30) ? 30 : ((FRAC_BITS < 1) ? 1 : FRAC_BITS);
   localparam longint SAT_HIGH = (longint'(1) <<< (SAT_BITS - 1)) - 1;
   localparam longint SAT_LOW  = -SAT_HIGH - 1;
   localparam longint Q_ONE    = longint'(1) <<< Q_BITS;
   localparam longint REG_MAX  = 64'sh7FFF_FFFF;

   typedef struct {
      word_type estimate;
      word_type gain;
      logic     overflow;
   } filter_out_type;

   filter_out_type predicted_outputs[$];
   longint trans_gain, obs_gain, proc_var, meas_var, est_state, var_state;
   bit clipped;

   function automatic longint clip(input longint v);
      if (v > SAT_HIGH) begin
         clipped = 1'b1;
         return SAT_HIGH;
      end
      if (v < SAT_LOW) begin
         clipped = 1'b1;
         return SAT_LOW;
      end
      return v;
   endfunction

   function automatic longint q_mul(input longint a, input longint b);
      return clip((a * b + (Q_ONE >>> 1)) >>> Q_BITS);
   endfunction

   function automatic longint q_add(input longint a, input longint b);
      return clip(a + b);
   endfunction

   function automatic longint scaled(input longint units);
      return (units * Q_ONE > REG_MAX) ? REG_MAX : units * Q_ONE;
   endfunction

   function automatic void load_defaults();
      trans_gain = scaled(1);
      obs_gain   = scaled(1);
      proc_var   = scaled(200);
      meas_var   = scaled(500);
      est_state  = 0;
      var_state  = clip(scaled(1));
   endfunction

   function automatic void apply_write(input logic [CSR_INDEX_BITS-1:0] idx,
                                       input word_type data);
      case (idx)
         REG_TRANSITION:  trans_gain = longint'(data);
         REG_OBSERVATION: obs_gain   = longint'(data);
         REG_PROC_NOISE:  proc_var   = longint'(data[VAR_BITS-1:0]);
         REG_MEAS_NOISE:  meas_var   = longint'(data[VAR_BITS-1:0]);
         REG_INIT_EST:    est_state  = clip(longint'(data));
         REG_INIT_VAR:    var_state  = clip(longint'(data[VAR_BITS-1:0]));
         default: ;
      endcase
   endfunction

   function automatic filter_out_type filter_step(input word_type z);
      longint x1, p1, ph, den, gain, innov, x2, p2;
      filter_out_type outcome;
      clipped = 1'b0;
      x1 = q_mul(trans_gain, est_state);
      p1 = q_add(q_mul(q_mul(trans_gain, trans_gain), var_state), proc_var);
      ph = q_mul(p1, obs_gain);
      den = q_add(q_mul(ph, obs_gain), meas_var);
      if (den == 0) begin
         gain = 0;
         clipped = 1'b1;
      end else begin
         gain = clip((ph * Q_ONE) / den);
      end
      innov = q_add(longint'(z), -q_mul(obs_gain, x1));
      x2 = q_add(x1, q_mul(gain, innov));
      p2 = q_mul(q_add(Q_ONE, -q_mul(gain, obs_gain)), p1);
      est_state = x2;
      var_state = p2;
      outcome.estimate = word_type'(x2);
      outcome.gain     = word_type'(gain);
      outcome.overflow = clipped;
      return outcome;
   endfunction

   always @(posedge clock) begin : monitor
      filter_out_type want;
      int unsigned fails;
      fails = 0;
      if (reset) begin
         load_defaults();
         predicted_outputs.delete();
         pending_results <= 0;
         mismatch_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            apply_write(csr_index, csr_data);
         end
         if (req_valid && req_ready) begin
            predicted_outputs.push_back(filter_step(req_measurement));
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_outputs.size() == 0) begin
               $error("Response with no request outstanding: estimate %0d", rsp_estimate);
               fails++;
            end else begin
               want = predicted_outputs.pop_front();
               if (rsp_estimate !== want.estimate) begin
                  $error("estimate: expected %0d, got %0d", want.estimate, rsp_estimate);
                  fails++;
               end
               if (rsp_kalman_gain !== want.gain) begin
                  $error("kalman_gain: expected %0d, got %0d", want.gain, rsp_kalman_gain);
                  fails++;
               end
               if (rsp_overflow_flag !== want.overflow) begin
                  $error("overflow_flag: expected %0b, got %0b", want.overflow,
                         rsp_overflow_flag);
                  fails++;
               end
            end
         end
         pending_results <= predicted_outputs.size();
         mismatch_count <= mismatch_count + fails;
      end
   end

endmodule

// ===== bench/tb_scalar_kalman_filter_core.sv =====
module tb_scalar_kalman_filter_core;
   timeunit 1ns;
   timeprecision 1ps;
   import skf_pkg::*;

   localparam int unsigned DATA_WIDTH      = 32;
   localparam int unsigned FRAC_BITS       = 16;
   localparam int unsigned RSP_LATENCY     = DATA_WIDTH + 26;
   localparam int unsigned RSP_HOLD_CYCLES = 600;
   localparam int unsigned PHASE_COUNT     = 20;
   localparam int unsigned STEADY_PHASE    = 6;
   localparam int unsigned HOLD_PHASE      = 10;
   localparam int unsigned PAUSE_PHASE     = 14;
   localparam int          REG_SPARE_FIRST = int'(REG_INIT_VAR) + 1;
   localparam word_type    WORD_MAX        = 32'sh7FFF_FFFF;
   localparam word_type    WORD_MIN        = 32'sh8000_0000;
   localparam word_type    Q_ONE           = word_type'(1 << FRAC_BITS);
   localparam word_type    DEF_PROC        = word_type'(200 << FRAC_BITS);
   localparam word_type    DEF_MEAS        = word_type'(500 << FRAC_BITS);

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   word_type                  req_measurement = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   word_type                  rsp_estimate;
   word_type                  rsp_kalman_gain;
   logic                      rsp_overflow_flag;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   word_type                  csr_data = '0;
   int unsigned               pending_results;
   int unsigned               mismatch_count;

   bit       steady = 1'b0;
   bit       hold_responses = 1'b0;
   word_type measurement_feed[$];

   scalar_kalman_filter_core #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) dut (.*);

   skf_checker #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) filter_check (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic bit idle_now();
      return !steady && ($urandom_range(99) < 25);
   endfunction

   function automatic word_type near(input int centre, input int spread);
      return word_type'(centre + int'($urandom_range(0, 2 * spread)) - spread);
   endfunction

   function automatic word_type pick_extreme();
      case ($urandom_range(0, 4))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         3: return Q_ONE;
         default: return -1;
      endcase
   endfunction

   task automatic queue_measurement(input word_type z);
      while (measurement_feed.size() >= 2) @(posedge clock);
      measurement_feed.push_back(z);
   endtask

   // Returns once every request has been answered and nothing is on offer.
   task automatic wait_quiet();
      do @(posedge clock);
      while (measurement_feed.size() != 0 || req_valid || pending_results != 0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input word_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_setup(input word_type a, input word_type h, input word_type q,
                             input word_type r, input word_type x0, input word_type p0);
      wait_quiet();
      write_csr(REG_TRANSITION, a);
      write_csr(REG_OBSERVATION, h);
      write_csr(REG_PROC_NOISE, q);
      write_csr(REG_MEAS_NOISE, r);
      write_csr(REG_INIT_EST, x0);
      write_csr(REG_INIT_VAR, p0);
      csr_valid <= 1'b0;
   endtask

   initial begin : request_driver
      int unsigned gap_left;
      gap_left = 0;
      forever begin
         @(posedge clock);
         if (req_valid && req_ready) begin
            void'(measurement_feed.pop_front());
            if (idle_now()) gap_left = $urandom_range(1, 120);
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (measurement_feed.size() != 0) begin
               req_valid <= 1'b1;
               req_measurement <= measurement_feed[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   initial begin : response_sink
      forever begin
         @(posedge clock);
         if (hold_responses) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            hold_responses = 1'b0;
         end else begin
            rsp_ready <= !idle_now();
         end
      end
   end

   initial begin
      #25_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      int unsigned items;
      int track_centre;
      int track_spread;
      word_type obs;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      queue_measurement('0);
      queue_measurement(WORD_MAX);
      queue_measurement(WORD_MIN);
      queue_measurement(-1);
      queue_measurement(word_type'(1));
      queue_measurement(32'sh5555_5555);
      queue_measurement(32'shAAAA_AAAA);

      // With no observation gain and no measurement noise the denominator is zero.
      load_setup(Q_ONE, '0, DEF_PROC, '0, '0, Q_ONE);
      queue_measurement(word_type'(100 << FRAC_BITS));
      queue_measurement(word_type'(-(7 << FRAC_BITS)));

      load_setup(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      queue_measurement(WORD_MAX);
      queue_measurement('0);

      load_setup(WORD_MIN, WORD_MIN, '0, '0, WORD_MIN, '0);
      queue_measurement(WORD_MIN);
      queue_measurement(WORD_MAX);

      // Writes to unused indexes must leave the filter untouched.
      load_setup(Q_ONE, Q_ONE, DEF_PROC, DEF_MEAS, '0, Q_ONE);
      for (int i = REG_SPARE_FIRST; i < (1 << CSR_INDEX_BITS); i++) begin
         write_csr(CSR_INDEX_BITS'(i), WORD_MAX);
      end
      csr_valid <= 1'b0;
      queue_measurement(word_type'(3 << FRAC_BITS));
      queue_measurement(word_type'(-(2 << FRAC_BITS)));
      queue_measurement(word_type'(5 << FRAC_BITS));

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 5)
            3: load_setup(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                          pick_extreme(), pick_extreme());
            4: load_setup($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            default: begin
               obs = near(Q_ONE, Q_ONE / 4);
               if ($urandom_range(3) == 0) obs = -obs;
               load_setup(near(Q_ONE, Q_ONE / 8), obs, $urandom_range(0, 400 << FRAC_BITS),
                          $urandom_range(1, 2000 << FRAC_BITS), near(0, 1000 << FRAC_BITS),
                          $urandom_range(0, 2000 << FRAC_BITS));
            end
         endcase
         steady = (phase == STEADY_PHASE);
         track_centre = near(0, 1000 << FRAC_BITS);
         track_spread = $urandom_range(1, 20 << FRAC_BITS);
         items = $urandom_range(50, 75);
         for (int n = 0; n < items; n++) begin
            if (phase == HOLD_PHASE && n == 5) hold_responses = 1'b1;
            if (phase == PAUSE_PHASE && n == 30) wait_quiet();
            if ($urandom_range(99) < 85) begin
               queue_measurement(near(track_centre, track_spread));
            end else begin
               queue_measurement(word_type'($urandom));
            end
         end
      end

      wait_quiet();
      repeat (2 * RSP_LATENCY) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/skf_pkg.sv
rtl/skf_div.sv
rtl/skf_dp.sv
rtl/skf_ctrl.sv
rtl/scalar_kalman_filter_core.sv
rtl/skf_chk.sv
bench/skf_checker.sv
bench/tb_scalar_kalman_filter_core.sv
